// ----- rtl/core/mces_pkg.sv -----
`timescale 1ns / 1ps

package mces_pkg;

	localparam int NUM_REGS     = 6;
	localparam int REG_IDX_W    = 3;
	localparam int DATA_W       = 32;
	localparam int SEC_W        = 8;
	localparam int MAX_SECONDS  = 127;
	localparam int OP_W         = 3;
	localparam int SLOT_IN_W    = 4;
	localparam int CSEL_W       = 3;
	localparam int IN_TDATA_W   = 72;
	localparam int OUT_TDATA_W  = 72;

	// rate registers after reset: cpu, clock1 .. clock5
	localparam logic [DATA_W-1:0] RATE_RESET [NUM_REGS] = '{
		32'd0, 32'd0, 32'd0, 32'd27000000, 32'd12000000, 32'd32768
	};

	localparam logic [SEC_W-1:0] SEC_INACTIVE = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_ADVANCE = 3'd0,
		OP_SET     = 3'd1,
		OP_REPEAT  = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_ADV_ADD,
		ACT_SCAN_INIT,
		ACT_SCAN_STEP,
		ACT_FIRE,
		ACT_ROLL,
		ACT_MOD_START,
		ACT_MOD_DONE,
		ACT_SET_MUL,
		ACT_DIV_PROD_R0,
		ACT_SET_PREV,
		ACT_REP_PREV,
		ACT_AT_DIV,
		ACT_AT_FIX,
		ACT_AT_MUL,
		ACT_AT_DIV2,
		ACT_AT_DUE,
		ACT_CLEAR,
		ACT_Q_MUL,
		ACT_Q_M,
		ACT_Q_REM,
		ACT_OUT
	} act_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_CHECK,
		ST_MOD_WAIT,
		ST_SET_DIV,
		ST_SET_WAIT,
		ST_AT_DIV,
		ST_AT_WAIT,
		ST_AT_MUL,
		ST_AT_DIV2,
		ST_AT_WAIT2,
		ST_Q_DIV,
		ST_Q_WAIT,
		ST_Q_REM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		act_t act;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic slot_ok;
		logic scan_last;
		logic adv_due;
		logic best_ev;
		logic any_counting;
		logic div_done;
	} dp_stat_t;

endpackage

// ----- rtl/core/mces_div.sv -----
`timescale 1ns / 1ps

// 64 by 32 restoring divider, one quotient bit per cycle.
// Keeps the low 32 bits of the quotient; a zero divisor gives garbage.
module mces_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	import mces_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        ge;

	// one shift-subtract step
	assign rem_sh = {rem_q, dvd_q[63]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], ge};
			dvd_q <= {dvd_q[62:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/mces_dp.sv -----
`timescale 1ns / 1ps

// Scheduler datapath: rate registers, slot table, time base, one multiplier,
// the shared divider and the result register.
module mces_dp #(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_CLOCKS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [mces_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [mces_pkg::DATA_W-1:0]         cfg_data,
	input  logic [mces_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  logic [mces_pkg::OP_W-1:0]           in_tuser,
	input  mces_pkg::ctrl_cmd_t                 cmd,
	output mces_pkg::dp_stat_t                  stat,
	output logic [mces_pkg::OUT_TDATA_W-1:0]    out_tdata,
	output logic                                out_tuser
);
	import mces_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// configuration and time base
	logic [DATA_W-1:0] rate_q [NUM_REGS];
	logic [DATA_W-1:0] cur_q;

	// slot table
	logic              slot_en_q  [NUM_SLOTS];
	logic [SEC_W-1:0]  slot_sec_q [NUM_SLOTS];
	logic [DATA_W-1:0] slot_tick_q[NUM_SLOTS];
	logic [DATA_W-1:0] slot_due_q [NUM_SLOTS];
	logic [CSEL_W-1:0] slot_clk_q [NUM_SLOTS];

	// latched word
	op_t               op_q;
	logic              slot_ok_q;
	logic [SLOT_W-1:0] sel_q;
	logic [CSEL_W-1:0] csel_q;
	logic [DATA_W-1:0] ticks_q;
	logic [DATA_W-1:0] elapsed_q;

	// scan and work registers
	logic [SLOT_W-1:0] idx_q;
	logic [DATA_W-1:0] best_due_q;
	logic              best_ev_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [63:0]       prod_q;
	logic [DATA_W-1:0] prev_q;
	logic [DATA_W-1:0] r_q;
	logic [DATA_W-1:0] m_q;
	logic              fired_q;
	logic [SLOT_W-1:0] fslot_q;
	logic [DATA_W-1:0] remain_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_user_q;

	// entry read port
	logic [SLOT_W-1:0] rd_idx;
	logic              en_rd;
	logic [SEC_W-1:0]  sec_rd;
	logic [DATA_W-1:0] tick_rd;
	logic [DATA_W-1:0] due_rd;
	logic [DATA_W-1:0] rate0;
	logic [DATA_W-1:0] rate_cur;
	logic [DATA_W-1:0] rate_sel;

	// arithmetic
	logic [63:0]       div_dvd;
	logic [31:0]       div_dsr;
	logic              div_start;
	logic              div_done;
	logic [31:0]       div_quo;
	logic [31:0]       div_rem;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [DATA_W-1:0] at_q;
	logic [DATA_W-1:0] at_t;
	logic              at_bump;
	logic [DATA_W-1:0] at_sec;
	logic [DATA_W-1:0] at_tick;
	logic [SEC_W-1:0]  at_sec_sat;
	logic              any_cnt;
	logic [DATA_W-1:0] to_next;

	function automatic logic [DATA_W-1:0] rate_of(input logic [CSEL_W-1:0] c,
		input logic [DATA_W-1:0] r0, input logic [DATA_W-1:0] r1,
		input logic [DATA_W-1:0] r2, input logic [DATA_W-1:0] r3,
		input logic [DATA_W-1:0] r4, input logic [DATA_W-1:0] r5);
		logic [DATA_W-1:0] r;
		case (c)
			3'd0:    r = r0;
			3'd1:    r = r1;
			3'd2:    r = r2;
			3'd3:    r = r3;
			3'd4:    r = r4;
			3'd5:    r = r5;
			default: r = '0;
		endcase
		if (int'(c) >= NUM_CLOCKS) r = '0;
		return r;
	endfunction

	assign rd_idx   = (cmd.act == ACT_SCAN_STEP) ? idx_q : sel_q;
	assign en_rd    = slot_en_q[rd_idx];
	assign sec_rd   = slot_sec_q[rd_idx];
	assign tick_rd  = slot_tick_q[rd_idx];
	assign due_rd   = slot_due_q[rd_idx];
	assign rate0    = rate_q[0];
	assign rate_cur = rate_of(slot_clk_q[rd_idx], rate_q[0], rate_q[1], rate_q[2],
		rate_q[3], rate_q[4], rate_q[5]);
	assign rate_sel = rate_of(csel_q, rate_q[0], rate_q[1], rate_q[2],
		rate_q[3], rate_q[4], rate_q[5]);

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = prod_q;
		div_dsr   = rate0;
		case (cmd.act)
			ACT_MOD_START: begin
				div_start = 1'b1;
				div_dvd   = {32'd0, cur_q};
			end
			ACT_DIV_PROD_R0: begin
				div_start = 1'b1;
			end
			ACT_AT_DIV: begin
				div_start = 1'b1;
				div_dvd   = {32'd0, ticks_q};
				div_dsr   = rate_cur;
			end
			ACT_AT_DIV2: begin
				div_start = 1'b1;
				div_dsr   = r_q;
			end
			default: ;
		endcase
	end

	mces_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// multiplier operand select
	always_comb begin
		mul_a = cur_q;
		mul_b = rate_sel;
		case (cmd.act)
			ACT_Q_MUL: mul_b = rate_cur;
			ACT_AT_MUL: begin
				mul_a = tick_rd;
				mul_b = rate0;
			end
			ACT_Q_M: begin
				mul_a = {{(DATA_W-SEC_W){sec_rd[SEC_W-1]}}, sec_rd};
				mul_b = r_q;
			end
			default: ;
		endcase
	end

	// tick addition with carry into seconds
	assign at_q       = (r_q == '0) ? '0 : div_quo;
	assign at_t       = (r_q == '0) ? '0 : div_rem;
	assign at_bump    = prev_q >= (r_q - at_t);
	assign at_sec     = at_q + {{(DATA_W-1){1'b0}}, at_bump};
	assign at_tick    = (at_bump ? (at_t - r_q) : at_t) + prev_q;
	assign at_sec_sat = (at_sec > DATA_W'(MAX_SECONDS)) ? SEC_W'(MAX_SECONDS) : at_sec[SEC_W-1:0];

	always_comb begin
		any_cnt = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!slot_sec_q[i][SEC_W-1]) any_cnt = 1'b1;
		end
	end

	assign to_next = (best_due_q > cur_q) ? (best_due_q - cur_q) : '0;

	// state that reset initialises
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) rate_q[i] <= RATE_RESET[i];
			cur_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_en_q[i]   <= 1'b0;
				slot_sec_q[i]  <= '0;
				slot_tick_q[i] <= '0;
				slot_due_q[i]  <= '0;
				slot_clk_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && int'(cfg_index) < NUM_REGS) rate_q[cfg_index] <= cfg_data;
			case (cmd.act)
				ACT_ADV_ADD:   cur_q <= cur_q + elapsed_q;
				ACT_SCAN_INIT: idx_q <= '0;
				ACT_SCAN_STEP: idx_q <= idx_q + 1'b1;
				ACT_FIRE:      slot_sec_q[best_slot_q] <= SEC_INACTIVE;
				ACT_ROLL: begin
					cur_q <= cur_q - rate0;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!slot_sec_q[i][SEC_W-1]) slot_sec_q[i] <= slot_sec_q[i] - 1'b1;
					end
				end
				ACT_MOD_DONE: cur_q <= div_rem;
				ACT_SET_MUL: begin
					slot_clk_q[sel_q] <= csel_q;
					slot_en_q[sel_q]  <= 1'b1;
				end
				ACT_AT_FIX: begin
					slot_sec_q[sel_q]  <= at_sec_sat;
					slot_tick_q[sel_q] <= at_tick;
				end
				ACT_AT_DUE: slot_due_q[sel_q] <= (r_q == '0) ? '0 : div_quo;
				ACT_CLEAR:  slot_sec_q[sel_q] <= SEC_INACTIVE;
				default: ;
			endcase
		end
	end

	// word latch, scan and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op_t'(in_tuser);
			slot_ok_q <= int'(in_tdata[3:0]) < NUM_SLOTS;
			sel_q     <= SLOT_W'(in_tdata[3:0]);
			csel_q    <= in_tdata[6:4];
			ticks_q   <= in_tdata[38:7];
			elapsed_q <= in_tdata[70:39];
			fired_q   <= 1'b0;
			fslot_q   <= '0;
			remain_q  <= '0;
		end
		case (cmd.act)
			ACT_SCAN_INIT: begin
				best_due_q  <= rate0;
				best_ev_q   <= 1'b0;
				best_slot_q <= '0;
			end
			ACT_SCAN_STEP: begin
				if (en_rd && sec_rd == '0 && due_rd < best_due_q) begin
					best_due_q  <= due_rd;
					best_ev_q   <= 1'b1;
					best_slot_q <= idx_q;
				end
			end
			ACT_FIRE: begin
				fired_q <= 1'b1;
				fslot_q <= best_slot_q;
			end
			ACT_SET_MUL, ACT_Q_MUL, ACT_AT_MUL: prod_q <= mul_a * mul_b;
			ACT_SET_PREV: prev_q <= (rate0 == '0) ? '0 : div_quo;
			ACT_REP_PREV: prev_q <= tick_rd;
			ACT_Q_M: begin
				m_q    <= (rate0 == '0) ? '0 : div_quo;
				prod_q <= mul_a * mul_b;
			end
			ACT_Q_REM: remain_q <= prod_q[DATA_W-1:0] + tick_rd - m_q;
			ACT_OUT: begin
				out_data_q <= {4'd0, to_next, remain_q, SLOT_IN_W'(fslot_q)};
				out_user_q <= fired_q;
			end
			default: ;
		endcase
		if (cmd.act == ACT_AT_DIV || cmd.act == ACT_Q_MUL) r_q <= rate_cur;
	end

	assign stat.op           = op_q;
	assign stat.slot_ok      = slot_ok_q;
	assign stat.scan_last    = idx_q == SLOT_W'(NUM_SLOTS - 1);
	assign stat.adv_due      = (rate0 != '0) && (cur_q >= best_due_q);
	assign stat.best_ev      = best_ev_q;
	assign stat.any_counting = any_cnt;
	assign stat.div_done     = div_done;

	assign out_tdata = out_data_q;
	assign out_tuser = out_user_q;

endmodule

// ----- rtl/core/mces_ctrl.sv -----
`timescale 1ns / 1ps

// Scheduler sequencer: takes a word, steps the datapath through the
// operation, the slot scan and the rollover loop, then hands off the result.
module mces_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_tvalid,
	output logic                 in_tready,
	output logic                 out_tvalid,
	input  logic                 out_tready,
	input  mces_pkg::dp_stat_t   stat,
	output mces_pkg::ctrl_cmd_t  cmd
);
	import mces_pkg::*;

	state_t state_q, state_d;
	logic   chk_q, chk_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chk_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q   <= chk_d;
			if (cmd.act == ACT_OUT) out_valid_q <= 1'b1;
			else if (out_tready)    out_valid_q <= 1'b0;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		chk_d     = chk_q;
		cmd.load  = 1'b0;
		cmd.act   = ACT_NONE;
		in_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				chk_d   = 1'b0;
				state_d = ST_SCAN_INIT;
				unique case (stat.op)
					OP_ADVANCE: begin
						cmd.act = ACT_ADV_ADD;
						chk_d   = 1'b1;
					end
					OP_SET: if (stat.slot_ok) begin
						cmd.act = ACT_SET_MUL;
						state_d = ST_SET_DIV;
					end
					OP_REPEAT: if (stat.slot_ok) begin
						cmd.act = ACT_REP_PREV;
						state_d = ST_AT_DIV;
					end
					OP_CLEAR: if (stat.slot_ok) cmd.act = ACT_CLEAR;
					OP_QUERY: if (stat.slot_ok) begin
						cmd.act = ACT_Q_MUL;
						state_d = ST_Q_DIV;
					end
					default: ;
				endcase
			end
			ST_SCAN_INIT: begin
				cmd.act = ACT_SCAN_INIT;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.act = ACT_SCAN_STEP;
				if (stat.scan_last) state_d = chk_q ? ST_CHECK : ST_OUT;
			end
			// advance loop: finish, fire, roll one second, or fold all idle seconds
			ST_CHECK: begin
				if (!stat.adv_due) begin
					state_d = ST_OUT;
				end else if (stat.best_ev) begin
					cmd.act = ACT_FIRE;
					chk_d   = 1'b0;
					state_d = ST_SCAN_INIT;
				end else if (stat.any_counting) begin
					cmd.act = ACT_ROLL;
					state_d = ST_SCAN_INIT;
				end else begin
					cmd.act = ACT_MOD_START;
					state_d = ST_MOD_WAIT;
				end
			end
			ST_MOD_WAIT: if (stat.div_done) begin
				cmd.act = ACT_MOD_DONE;
				state_d = ST_SCAN_INIT;
			end
			ST_SET_DIV: begin
				cmd.act = ACT_DIV_PROD_R0;
				state_d = ST_SET_WAIT;
			end
			ST_SET_WAIT: if (stat.div_done) begin
				cmd.act = ACT_SET_PREV;
				state_d = ST_AT_DIV;
			end
			ST_AT_DIV: begin
				cmd.act = ACT_AT_DIV;
				state_d = ST_AT_WAIT;
			end
			ST_AT_WAIT: if (stat.div_done) begin
				cmd.act = ACT_AT_FIX;
				state_d = ST_AT_MUL;
			end
			ST_AT_MUL: begin
				cmd.act = ACT_AT_MUL;
				state_d = ST_AT_DIV2;
			end
			ST_AT_DIV2: begin
				cmd.act = ACT_AT_DIV2;
				state_d = ST_AT_WAIT2;
			end
			ST_AT_WAIT2: if (stat.div_done) begin
				cmd.act = ACT_AT_DUE;
				state_d = ST_SCAN_INIT;
			end
			ST_Q_DIV: begin
				cmd.act = ACT_DIV_PROD_R0;
				state_d = ST_Q_WAIT;
			end
			ST_Q_WAIT: if (stat.div_done) begin
				cmd.act = ACT_Q_M;
				state_d = ST_Q_REM;
			end
			ST_Q_REM: begin
				cmd.act = ACT_Q_REM;
				state_d = ST_SCAN_INIT;
			end
			ST_OUT: if (out_free) begin
				cmd.act = ACT_OUT;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_tvalid = out_valid_q;

endmodule

// ----- rtl/core/multi_clock_event_scheduler_unit.sv -----
`timescale 1ns / 1ps

// Multi-clock event scheduler.
// Command words enter on s_axis (op in tuser, operands in tdata); each word
// yields exactly one result word on m_axis (fired flag in tuser). Rate
// registers are written on the cfg channel, index 0 = CPU rate, 1..5 = clock
// domains; cfg_ready is always high, and writes belong between commands.
// One word is in flight at a time. Every word ends with a slot scan over
// all NUM_SLOTS slots. Clear and unknown ops go straight to the scan;
// query, repeat and set first run their 64-by-32 divisions, and each
// division holds the shared bit-serial divider until it is done.
// Advance scans, then loops while an event is due: it rolls one second
// (at most 128 rollovers per advance), folds all idle seconds at the
// end, or fires a due event, which ends the advance after its rescan.
// The result sits in an output register; the next word is taken as soon as
// the block is done, while the result may still wait. A stalled result
// holds its data, and the block holds its finished word until the register
// frees. Reset restores the rate defaults, zeroes the time base and clears
// all slot fields; no clearing pass follows.
module multi_clock_event_scheduler_unit #(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_CLOCKS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mces_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [mces_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// slot[3:0], clock_select[6:4], tick_count[38:7], elapsed_cycles[70:39]
	input  logic [mces_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// op[2:0]
	input  logic [mces_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// fired_slot[3:0], remaining_ticks[35:4], cycles_to_next[67:36]
	output logic [mces_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// fired[0]
	output logic                                m_axis_tuser
);
	import mces_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	mces_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mces_dp #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_CLOCKS (NUM_CLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

endmodule
